[rtl/nbbr_pkg.sv]
package nbbr_pkg;

  typedef enum logic [1:0] {
    OP_SCAN      = 2'd0,
    OP_TRANSLATE = 2'd1,
    OP_REMAP     = 2'd2,
    OP_UNUSED    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_RANGE     = 3'd1,
    STATUS_TAG_RANGE = 3'd2,
    STATUS_DUPLICATE = 3'd3,
    STATUS_SCAN_ERR  = 3'd4,
    STATUS_NO_SPARE  = 3'd5,
    STATUS_SCAN_OVER = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } fsm_t;

  typedef enum logic [1:0] {
    REG_PAGE_SHIFT    = 2'd0,
    REG_PHYS_COUNT    = 2'd1,
    REG_LOGICAL_COUNT = 2'd2
  } reg_idx_t;

  localparam logic [1:0]  SCAN_GOOD = 2'd0;
  localparam logic [1:0]  SCAN_BAD  = 2'd1;
  localparam logic [15:0] UNTAGGED  = 16'hFFFF;

  localparam logic [3:0]  MAX_PAGE_SHIFT = 4'd8;

  localparam logic [3:0]  PAGE_SHIFT_RESET    = 4'd6;
  localparam logic [12:0] PHYS_COUNT_RESET    = 13'd4096;
  localparam logic [12:0] LOGICAL_COUNT_RESET = 13'd4000;

endpackage

[rtl/nand_bad_block_remap.sv]
// NAND bad block remapper: keeps the logical-to-physical block table.
// Input items arrive on the s_ stream (op in s_tuser), one result per item
// leaves on the m_ stream; an item with the unused op code is taken and
// gives no result. Three registers (page shift, physical and logical block
// counts) are written and read back through the APB port.
// Scan items, one per physical block in order from block 0, build the table;
// translate items look up a logical page, remap items assign the next spare.
// At transfer an item reads the table memory at its logical block; in the
// execute state, once the output register is free, the entry is checked, the
// table rewritten and the output register loaded, a single read-modify-write
// pass; only then is a new item taken. An item is accepted while a result
// still waits in the output register; it then holds in its execute step until
// m_tready frees the register, and s_tready stays low meanwhile. The user must
// write the registers only while no item is in flight; the block itself does
// not enforce it. After reset the table memory is cleared one entry per cycle
// with s_tready low; register writes are taken during that time. Reset also
// empties the output register and restarts the scan.
module nand_bad_block_remap #(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // logical_page[19:0], logical_block[31:20], scan_status[33:32], scan_tag[49:34]
  input  logic [55:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], physical_page[22:3], physical_block[34:23],
  // previous_block[46:35], block_tag[58:47], scan_finished[59],
  // bad_block_count[72:60]
  output logic [79:0] m_tdata
);
  import nbbr_pkg::*;

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = AW + 1;
  localparam int MW = AW + 1;

  // Configuration registers
  logic [3:0]  page_shift;
  logic [12:0] phys_count;
  logic [12:0] logical_count;
  logic        cfg_write;
  reg_idx_t    cfg_idx;

  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift    <= PAGE_SHIFT_RESET;
      phys_count    <= PHYS_COUNT_RESET;
      logical_count <= LOGICAL_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_PAGE_SHIFT:    page_shift    <= pwdata[3:0];
        REG_PHYS_COUNT:    phys_count    <= pwdata[12:0];
        REG_LOGICAL_COUNT: logical_count <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PAGE_SHIFT:    prdata = 32'(page_shift);
      REG_PHYS_COUNT:    prdata = 32'(phys_count);
      REG_LOGICAL_COUNT: prdata = 32'(logical_count);
      default:           prdata = '0;
    endcase
  end

  // Counts above the table size act as the table size; a page shift above MAX_PAGE_SHIFT acts as MAX_PAGE_SHIFT.
  logic [3:0]    sh;
  logic [CW-1:0] pbc;
  logic [CW-1:0] lbc;

  assign sh  = (page_shift > MAX_PAGE_SHIFT) ? MAX_PAGE_SHIFT : page_shift;
  assign pbc = (32'(phys_count) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(phys_count);
  assign lbc = (32'(logical_count) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(logical_count);

  // Control state
  fsm_t          state;
  fsm_t          state_next;
  logic [AW-1:0] clr_addr;
  logic          exec_go;
  logic          in_xfer;

  logic [CW-1:0] scan_physical, scan_physical_next;
  logic [CW-1:0] scan_logical, scan_logical_next;
  logic          scan_done, scan_done_next;
  logic [CW-1:0] next_spare, next_spare_next;
  logic          spares_exhausted, spares_exhausted_next;
  logic [CW-1:0] bad_blocks, bad_blocks_next;

  // Item held for its execute step
  op_t         it_op;
  logic [19:0] it_lpage;
  logic [11:0] it_lblock;
  logic [1:0]  it_sstat;
  logic [15:0] it_stag;

  // Table memory: valid bit over the physical block number.
  logic [MW-1:0] mem [MAX_BLOCKS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [MW-1:0] mem_rdata;

  // Output register
  status_t     o_status;
  logic [19:0] o_ppage;
  logic [11:0] o_pblock;
  logic [11:0] o_prev;
  logic [11:0] o_tag;
  logic        o_finished;
  logic [12:0] o_bad;

  // Result of the execute step
  status_t     r_status;
  logic [19:0] r_ppage;
  logic [11:0] r_pblock;
  logic [11:0] r_prev;
  logic [11:0] r_tag;
  logic          x_we;
  logic [AW-1:0] x_waddr;
  logic [MW-1:0] x_wdata;

  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign exec_go  = (state == ST_EXEC) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(MAX_BLOCKS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer && op_t'(s_tuser) != OP_UNUSED) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Read address at the transfer cycle: the logical block the item touches.
  always_comb begin
    logic [19:0] lb_in;
    lb_in = s_tdata[19:0] >> sh;
    case (op_t'(s_tuser))
      OP_SCAN:      mem_raddr = AW'(32'(s_tdata[49:34]));
      OP_TRANSLATE: mem_raddr = AW'(32'(lb_in));
      default:      mem_raddr = AW'(32'(s_tdata[31:20]));
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      it_op     <= op_t'(s_tuser);
      it_lpage  <= s_tdata[19:0];
      it_lblock <= s_tdata[31:20];
      it_sstat  <= s_tdata[33:32];
      it_stag   <= s_tdata[49:34];
    end
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = x_we && exec_go;
      mem_waddr = x_waddr;
      mem_wdata = x_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_xfer) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // Execute step: check the entry, update the table and the scan state.
  always_comb begin
    logic          rd_valid;
    logic [AW-1:0] rd_blk;
    logic          done0;
    logic [19:0]   lb;
    logic [19:0]   off;
    logic [CW-1:0] spare_inc;

    rd_valid  = mem_rdata[MW-1];
    rd_blk    = mem_rdata[AW-1:0];
    done0     = scan_done || (scan_physical >= pbc) || (scan_logical >= lbc);
    lb        = it_lpage >> sh;
    off       = it_lpage & ((20'd1 << sh) - 20'd1);
    spare_inc = next_spare + CW'(1);

    r_status = STATUS_OK;
    r_ppage  = '0;
    r_pblock = '0;
    r_prev   = '0;
    r_tag    = '0;
    x_we     = 1'b0;
    x_waddr  = mem_raddr;
    x_wdata  = {1'b1, AW'(scan_physical)};

    scan_physical_next    = scan_physical;
    scan_logical_next     = scan_logical;
    scan_done_next        = scan_done;
    next_spare_next       = next_spare;
    spares_exhausted_next = spares_exhausted;
    bad_blocks_next       = bad_blocks;

    case (it_op)
      OP_SCAN: begin
        if (done0) begin
          r_status = STATUS_SCAN_OVER;
          if (!scan_done) begin
            scan_done_next        = 1'b1;
            next_spare_next       = scan_physical;
            spares_exhausted_next = (scan_physical >= pbc);
          end
        end else begin
          if (it_sstat == SCAN_BAD) begin
            bad_blocks_next    = bad_blocks + CW'(1);
            r_pblock           = 12'(scan_physical);
            scan_physical_next = scan_physical + CW'(1);
          end else if (it_sstat != SCAN_GOOD) begin
            r_status = STATUS_SCAN_ERR;
          end else if (it_stag == UNTAGGED) begin
            // An untagged block takes the next slot, even an occupied one.
            x_we               = 1'b1;
            x_waddr            = AW'(scan_logical);
            r_pblock           = 12'(scan_physical);
            r_tag              = 12'(scan_logical);
            scan_logical_next  = scan_logical + CW'(1);
            scan_physical_next = scan_physical + CW'(1);
          end else if (32'(it_stag) >= 32'(lbc)) begin
            r_status = STATUS_TAG_RANGE;
          end else if (rd_valid) begin
            r_status = STATUS_DUPLICATE;
          end else begin
            x_we               = 1'b1;
            x_waddr            = AW'(32'(it_stag));
            r_pblock           = 12'(scan_physical);
            r_tag              = 12'(it_stag);
            scan_logical_next  = scan_logical + CW'(1);
            scan_physical_next = scan_physical + CW'(1);
          end
          if ((scan_physical_next >= pbc) || (scan_logical_next >= lbc)) begin
            scan_done_next        = 1'b1;
            next_spare_next       = scan_physical_next;
            spares_exhausted_next = (scan_physical_next >= pbc);
          end
        end
      end
      OP_TRANSLATE: begin
        if ((32'(lb) >= 32'(lbc)) || !rd_valid) begin
          r_status = STATUS_RANGE;
        end else begin
          r_pblock = 12'(rd_blk);
          r_ppage  = 20'((32'(rd_blk) << sh) | 32'(off));
          r_tag    = 12'(lb);
        end
      end
      OP_REMAP: begin
        if (32'(it_lblock) >= 32'(lbc)) begin
          r_status = STATUS_RANGE;
        end else if (!scan_done || spares_exhausted || (next_spare >= pbc)) begin
          r_status = STATUS_NO_SPARE;
        end else begin
          r_prev                = rd_valid ? 12'(rd_blk) : 12'd0;
          r_pblock              = 12'(next_spare);
          r_tag                 = it_lblock;
          x_we                  = 1'b1;
          x_waddr               = AW'(32'(it_lblock));
          x_wdata               = {1'b1, AW'(next_spare)};
          next_spare_next       = spare_inc;
          spares_exhausted_next = spares_exhausted || (spare_inc >= pbc);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_physical    <= '0;
      scan_logical     <= '0;
      scan_done        <= 1'b0;
      next_spare       <= '0;
      spares_exhausted <= 1'b0;
      bad_blocks       <= '0;
    end else if (exec_go) begin
      scan_physical    <= scan_physical_next;
      scan_logical     <= scan_logical_next;
      scan_done        <= scan_done_next;
      next_spare       <= next_spare_next;
      spares_exhausted <= spares_exhausted_next;
      bad_blocks       <= bad_blocks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      o_status   <= r_status;
      o_ppage    <= r_ppage;
      o_pblock   <= r_pblock;
      o_prev     <= r_prev;
      o_tag      <= r_tag;
      o_finished <= scan_done_next;
      o_bad      <= 13'(bad_blocks_next);
    end
  end

  assign m_tdata = {7'd0, o_bad, o_finished, o_tag, o_prev, o_pblock, o_ppage, o_status};

`ifndef SYNTHESIS
  // A finished item always lands in the output register.
  a_exec_lands: assert property (@(posedge clk) disable iff (rst)
    exec_go |=> m_tvalid)
    else $error("result not presented after execution");

  // A failed item carries no block or tag.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_status != STATUS_OK) |-> (o_pblock == 12'd0 && o_tag == 12'd0))
    else $error("failed result carries block or tag");

  // Every bad block counted and every logical slot filled was also consumed by the scan.
  a_bad_le_phys: assert property (@(posedge clk) disable iff (rst)
    (bad_blocks <= scan_physical) && (scan_logical <= scan_physical))
    else $error("scan counters out of step");

  // The spare pointer never runs past the table.
  a_spare_bound: assert property (@(posedge clk) disable iff (rst)
    32'(next_spare) <= MAX_BLOCKS)
    else $error("spare pointer beyond table");

  // No item enters while the table is being cleared.
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!s_tready && !exec_go))
    else $error("item taken during table clear");
`endif

endmodule

[bench/nand_bad_block_remap_tb.sv]
module nand_bad_block_remap_tb;
  import nbbr_pkg::*;

  localparam int MAP_DEPTH = 4096;
  localparam logic [12:0] NO_MAP = '1;
  localparam int QUIET_LIMIT = 20000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    op_t         op;
    logic [19:0] page;
    logic [11:0] lblk;
    logic [1:0]  sst;
    logic [15:0] tag;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [19:0] ppage;
    logic [11:0] pblk;
    logic [11:0] prev;
    logic [11:0] tag;
    logic        done;
    logic [12:0] bad;
  } result_t;

  typedef struct packed {
    req_t    q;
    logic    fixed;
    result_t want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  // logical_page[19:0], logical_block[31:20], scan_status[33:32], scan_tag[49:34]
  logic [55:0] s_tdata;
  // op[1:0]
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  // status[2:0], physical_page[22:3], physical_block[34:23],
  // previous_block[46:35], block_tag[58:47], scan_finished[59],
  // bad_block_count[72:60]
  logic [79:0] m_tdata;

  nand_bad_block_remap dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // Predicted remapper state and register copies.
  logic [12:0] l2p_map [MAP_DEPTH];
  int unsigned scan_pblk;
  int unsigned scan_lblk;
  bit          scan_over;
  int unsigned spare_next;
  bit          spare_out;
  int unsigned bad_seen;
  logic [3:0]  cfg_shift;
  logic [12:0] cfg_pcount;
  logic [12:0] cfg_lcount;

  result_t pending_results [$];
  int      fail_cnt = 0;
  int      quiet_cycles = 0;
  bit      no_idle = 1'b0;
  bit      tx_quiet = 1'b0;
  bit      rx_quiet = 1'b0;
  bit      hold_request = 1'b0;

  row_t directed_rows [23];

  function automatic int unsigned shift_eff();
    return (cfg_shift > 4'd8) ? 8 : cfg_shift;
  endfunction

  function automatic int unsigned phys_lim();
    return (cfg_pcount > 13'd4096) ? 4096 : cfg_pcount;
  endfunction

  function automatic int unsigned log_lim();
    return (cfg_lcount > 13'd4096) ? 4096 : cfg_lcount;
  endfunction

  function automatic void map_reset();
    foreach (l2p_map[i]) l2p_map[i] = NO_MAP;
    scan_pblk = 0;
    scan_lblk = 0;
    scan_over = 1'b0;
    spare_next = 0;
    spare_out = 1'b0;
    bad_seen = 0;
    cfg_shift = PAGE_SHIFT_RESET;
    cfg_pcount = PHYS_COUNT_RESET;
    cfg_lcount = LOGICAL_COUNT_RESET;
  endfunction

  // The scan closes as soon as either count is reached, and the spare pool
  // starts right after the last physical block it consumed.
  function automatic void close_scan_if_due();
    if (!scan_over && (scan_pblk >= phys_lim() || scan_lblk >= log_lim())) begin
      scan_over = 1'b1;
      spare_next = scan_pblk;
      spare_out = (spare_next >= phys_lim());
    end
  endfunction

  task automatic remap_predict(input req_t q, output bit has_res, output result_t r);
    int unsigned lb;
    int unsigned off;
    int unsigned sh;
    int unsigned lim_l;
    int unsigned lim_p;
    r = '0;
    r.status = STATUS_OK;
    sh = shift_eff();
    lim_l = log_lim();
    lim_p = phys_lim();
    has_res = (q.op != OP_UNUSED);
    case (q.op)
      OP_SCAN: begin
        close_scan_if_due();
        if (scan_over) begin
          r.status = STATUS_SCAN_OVER;
        end else if (q.sst == SCAN_BAD) begin
          bad_seen++;
          r.pblk = 12'(scan_pblk);
          scan_pblk++;
        end else if (q.sst != SCAN_GOOD) begin
          r.status = STATUS_SCAN_ERR;
        end else if (q.tag == UNTAGGED) begin
          l2p_map[scan_lblk] = 13'(scan_pblk);
          r.pblk = 12'(scan_pblk);
          r.tag = 12'(scan_lblk);
          scan_lblk++;
          scan_pblk++;
        end else if (q.tag >= lim_l) begin
          r.status = STATUS_TAG_RANGE;
        end else if (l2p_map[q.tag] != NO_MAP) begin
          r.status = STATUS_DUPLICATE;
        end else begin
          l2p_map[q.tag] = 13'(scan_pblk);
          r.pblk = 12'(scan_pblk);
          r.tag = q.tag[11:0];
          scan_lblk++;
          scan_pblk++;
        end
        close_scan_if_due();
      end
      OP_TRANSLATE: begin
        lb = q.page >> sh;
        off = q.page & ((32'd1 << sh) - 1);
        if (lb >= lim_l || l2p_map[lb] == NO_MAP) begin
          r.status = STATUS_RANGE;
        end else begin
          r.pblk = l2p_map[lb][11:0];
          r.ppage = 20'((32'(l2p_map[lb]) << sh) | off);
          r.tag = 12'(lb);
        end
      end
      OP_REMAP: begin
        if (q.lblk >= lim_l) begin
          r.status = STATUS_RANGE;
        end else if (!scan_over || spare_out || spare_next >= lim_p) begin
          r.status = STATUS_NO_SPARE;
        end else begin
          r.prev = (l2p_map[q.lblk] == NO_MAP) ? 12'd0 : l2p_map[q.lblk][11:0];
          r.pblk = 12'(spare_next);
          l2p_map[q.lblk] = 13'(spare_next);
          spare_next++;
          if (spare_next >= lim_p) spare_out = 1'b1;
          r.tag = q.lblk;
        end
      end
      default: ;
    endcase
    r.done = scan_over;
    r.bad = 13'(bad_seen);
  endtask

  function automatic req_t req(op_t op, logic [19:0] page, logic [11:0] lblk,
                               logic [1:0] sst, logic [15:0] tag);
    req_t q;
    q.op = op;
    q.page = page;
    q.lblk = lblk;
    q.sst = sst;
    q.tag = tag;
    return q;
  endfunction

  // Results typed in by hand come before the scan ends, so scan_finished is low.
  function automatic result_t typed_res(status_t status, int unsigned pblk,
                                        int unsigned tag, int unsigned bad);
    result_t r;
    r = '0;
    r.status = status;
    r.pblk = 12'(pblk);
    r.tag = 12'(tag);
    r.bad = 13'(bad);
    return r;
  endfunction

  function automatic result_t unpack_result(logic [79:0] d);
    result_t r;
    r.status = status_t'(d[2:0]);
    r.ppage = d[22:3];
    r.pblk = d[34:23];
    r.prev = d[46:35];
    r.tag = d[58:47];
    r.done = d[59];
    r.bad = d[72:60];
    return r;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("status=%0d page=%05h block=%0d prev=%0d tag=%0d done=%0b bad=%0d",
                     r.status, r.ppage, r.pblk, r.prev, r.tag, r.done, r.bad);
  endfunction

  function automatic req_t random_request(int unsigned scan_w, int unsigned xlat_w,
                                          int unsigned remap_w);
    req_t q;
    int unsigned pick;
    int unsigned lb;
    int unsigned sh;
    sh = shift_eff();
    q.op = OP_UNUSED;
    q.page = 20'($urandom);
    q.lblk = 12'($urandom);
    q.sst = 2'($urandom);
    q.tag = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < scan_w) begin
      q.op = OP_SCAN;
      pick = $urandom_range(9);
      if (pick < 8) q.sst = SCAN_GOOD;
      else if (pick == 8) q.sst = SCAN_BAD;
      else q.sst = 2'($urandom_range(3, 2));
      pick = $urandom_range(99);
      if (pick < 60) q.tag = UNTAGGED;
      else if (pick < 92) q.tag = 16'($urandom_range(log_lim() + 20));
    end else if (pick < scan_w + xlat_w) begin
      q.op = OP_TRANSLATE;
      // Mostly aim at the slots the scan has filled.
      if ($urandom_range(9) < 7) begin
        lb = $urandom_range(scan_lblk + 8);
        q.page = 20'((lb << sh) | ($urandom & ((32'd1 << sh) - 1)));
      end
    end else if (pick < scan_w + xlat_w + remap_w) begin
      q.op = OP_REMAP;
      if ($urandom_range(9) < 8)
        q.lblk = 12'($urandom_range((log_lim() > 4095) ? 4095 : log_lim()));
    end
    return q;
  endfunction

  task automatic send_request(input req_t q, input bit fixed, input result_t fixed_res);
    result_t r;
    bit has_res;
    if (!no_idle && !tx_quiet && $urandom_range(5) == 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat ($urandom_range(18)) @(negedge clk);
    end
    if ($urandom_range(29) == 0) tx_quiet = !tx_quiet;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = q.op;
    s_tdata = {6'b0, q.tag, q.sst, q.lblk, q.page};
    do @(posedge clk); while (!s_tready);
    remap_predict(q, has_res, r);
    if (has_res) pending_results.push_back(fixed ? fixed_res : r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // An ignored item may still be inside the block.
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] kept;
    kept = (idx == REG_PAGE_SHIFT) ? {28'b0, val[3:0]} : {19'b0, val[12:0]};
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PAGE_SHIFT: cfg_shift = val[3:0];
      REG_PHYS_COUNT: cfg_pcount = val[12:0];
      REG_LOGICAL_COUNT: cfg_lcount = val[12:0];
      default: ;
    endcase
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== kept) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("register %0d read back %0h, wrote %0h", idx, prdata, kept);
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_config(input logic [31:0] shift, input logic [31:0] pcount,
                            input logic [31:0] lcount);
    wait_drained();
    reg_write(REG_PAGE_SHIFT, shift);
    reg_write(REG_PHYS_COUNT, pcount);
    reg_write(REG_LOGICAL_COUNT, lcount);
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned xlat_w,
                           input int unsigned remap_w);
    req_t q;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      if (scan_over) q = random_request(8, xlat_w, remap_w);
      else q = random_request(85, 7, 6);
      send_request(q, 1'b0, '0);
      if (q.op != OP_UNUSED) sent++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: random stall bursts, quiet stretches, and one long hold-off.
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else if (no_idle || rx_quiet) begin
        m_tready = 1'b1;
      end else if ($urandom_range(7) == 0) begin
        m_tready = 1'b0;
        hold_left = $urandom_range(18);
      end else begin
        m_tready = 1'b1;
      end
      if ($urandom_range(39) == 0) rx_quiet = !rx_quiet;
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = unpack_result(m_tdata);
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("result with none expected: %s", show(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch\n  expected %s\n  actual   %s", show(want), show(got));
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_SCAN;
    map_reset();

    // Reset counts: 4096 physical, 4000 logical, 64 pages per block.
    directed_rows = '{
      '{req(OP_REMAP, 20'd0, 12'd0, SCAN_GOOD, 16'd0), 1'b1,
        typed_res(STATUS_NO_SPARE, 0, 0, 0)},
      '{req(OP_REMAP, 20'd0, 12'd4095, SCAN_GOOD, 16'd0), 1'b1,
        typed_res(STATUS_RANGE, 0, 0, 0)},
      '{req(OP_TRANSLATE, 20'd0, 12'd0, SCAN_GOOD, 16'd0), 1'b1,
        typed_res(STATUS_RANGE, 0, 0, 0)},
      '{req(OP_TRANSLATE, 20'hFFFFF, 12'd0, SCAN_GOOD, 16'd0), 1'b1,
        typed_res(STATUS_RANGE, 0, 0, 0)},
      '{req(OP_UNUSED, 20'hABCDE, 12'h5A5, 2'd3, 16'hBEEF), 1'b0, '0},
      '{req(OP_SCAN, 20'd0, 12'd0, 2'd2, 16'd0), 1'b1,
        typed_res(STATUS_SCAN_ERR, 0, 0, 0)},
      '{req(OP_SCAN, 20'hFFFFF, 12'hFFF, 2'd3, UNTAGGED), 1'b1,
        typed_res(STATUS_SCAN_ERR, 0, 0, 0)},
      '{req(OP_SCAN, 20'd0, 12'd0, SCAN_BAD, 16'h1234), 1'b1,
        typed_res(STATUS_OK, 0, 0, 1)},
      '{req(OP_SCAN, 20'd0, 12'd0, SCAN_GOOD, UNTAGGED), 1'b1,
        typed_res(STATUS_OK, 1, 0, 1)},
      '{req(OP_SCAN, 20'd0, 12'd0, SCAN_GOOD, 16'd2), 1'b0, '0},
      // The untagged block lands on slot 2, which the tag just took.
      '{req(OP_SCAN, 20'd0, 12'd0, SCAN_GOOD, UNTAGGED), 1'b0, '0},
      '{req(OP_SCAN, 20'd0, 12'd0, SCAN_GOOD, 16'd2), 1'b1,
        typed_res(STATUS_DUPLICATE, 0, 0, 1)},
      '{req(OP_SCAN, 20'd0, 12'd0, SCAN_GOOD, 16'd4000), 1'b1,
        typed_res(STATUS_TAG_RANGE, 0, 0, 1)},
      '{req(OP_SCAN, 20'd0, 12'd0, SCAN_GOOD, 16'hFFFE), 1'b1,
        typed_res(STATUS_TAG_RANGE, 0, 0, 1)},
      '{req(OP_SCAN, 20'd0, 12'd0, SCAN_GOOD, 16'd3999), 1'b0, '0},
      '{req(OP_SCAN, 20'd0, 12'd0, SCAN_GOOD, 16'd0), 1'b0, '0},
      '{req(OP_SCAN, 20'd0, 12'd0, SCAN_BAD, UNTAGGED), 1'b0, '0},
      '{req(OP_TRANSLATE, 20'd63, 12'd0, SCAN_GOOD, 16'd0), 1'b0, '0},
      '{req(OP_TRANSLATE, 20'd255978, 12'd0, SCAN_GOOD, 16'd0), 1'b0, '0},
      '{req(OP_TRANSLATE, 20'd64, 12'd0, SCAN_GOOD, 16'd0), 1'b0, '0},
      '{req(OP_REMAP, 20'd0, 12'd3999, SCAN_GOOD, 16'd0), 1'b1,
        typed_res(STATUS_NO_SPARE, 0, 0, 2)},
      '{req(OP_REMAP, 20'd0, 12'd4000, SCAN_GOOD, 16'd0), 1'b1,
        typed_res(STATUS_RANGE, 0, 0, 2)},
      '{req(OP_SCAN, 20'd0, 12'd0, SCAN_GOOD, UNTAGGED), 1'b0, '0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_config(32'd6, 32'd4096, 32'd4000);
    foreach (directed_rows[i])
      send_request(directed_rows[i].q, directed_rows[i].fixed, directed_rows[i].want);

    // Small counts so the scan runs to its end and leaves a spare pool.
    set_config(32'd4, 32'd170, 32'd120);
    run_phase(50, 45, 20);
    hold_request = 1'b1;
    run_phase(100, 45, 20);
    wait_drained();
    run_phase(150, 45, 20);

    set_config(32'd8, 32'd170, 32'd4096);
    run_phase(80, 55, 30);
    set_config(32'd0, 32'd8191, 32'd8191);
    run_phase(60, 50, 30);
    set_config(32'd15, 32'd1, 32'd1);
    run_phase(40, 45, 40);
    set_config(32'd5, 32'd4096, 32'd120);
    run_phase(90, 60, 25);
    no_idle = 1'b1;
    run_phase(60, 60, 25);

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
